>>> sv/quaternion_to_euler_angles_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle block
// Same-cycle-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/qte_pkg.sv
// ---------------------------------------------------------------------------
// qte_pkg
// Shared widths, angle constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package qte_pkg;

  // vector component width entering the CORDIC
  localparam int VW = 36;
  // width after pre-rotation
  localparam int PW = 37;
  // CORDIC datapath width
  localparam int CW = 45;
  // angle accumulator width, 2^-16 degree
  localparam int AW = 26;
  // shift amount width
  localparam int SW = 6;
  // normalization target bit
  localparam int NORM_BIT = 40;
  localparam int TAB_LEN = 24;

  localparam logic signed [AW-1:0] DEG90 = 26'sd5898240;
  localparam logic signed [17:0] HEAD_FULL = 18'sd46080;
  localparam logic signed [17:0] ROLL_LIM = 18'sd23040;
  localparam logic signed [17:0] PITCH_LIM = 18'sd11520;

  localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
    26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115,
    26'sd57, 26'sd29, 26'sd14, 26'sd7,
    26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  // vectors and pitch flags carried alongside the square root
  typedef struct packed {
    logic signed [VW-1:0] hx;
    logic signed [VW-1:0] hy;
    logic signed [VW-1:0] rx;
    logic signed [VW-1:0] ry;
    logic signed [VW-1:0] p;
    logic                 nz;
    logic                 sp;
    logic                 sn;
  } side_t;

  typedef struct packed {
    logic nz;
    logic sp;
    logic sn;
  } flags_t;

endpackage

>>> sv/qte_cordic.sv
// ---------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2: pre-rotation, normalizing shift, then
// one micro-rotation per stage.
// ---------------------------------------------------------------------------
module qte_cordic #(
  parameter int ITER = 16
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [qte_pkg::VW-1:0]    x_i,
  input  logic signed [qte_pkg::VW-1:0]    y_i,
  output logic signed [qte_pkg::AW-1:0]    ang_o
);

  localparam int PW = qte_pkg::PW;
  localparam int CW = qte_pkg::CW;
  localparam int AW = qte_pkg::AW;
  localparam int SW = qte_pkg::SW;

  // pre-rotation into the right half plane
  logic signed [PW-1:0] xe, ye, px_d, py_d;
  logic signed [AW-1:0] pa_d;
  logic [PW-1:0]        ax, ay, m;
  logic [SW-1:0]        ps_d;
  logic                 pz_d;

  logic signed [PW-1:0] px_q, py_q;
  logic signed [AW-1:0] pa_q;
  logic [SW-1:0]        ps_q;
  logic                 pz_q;

  always_comb begin
    xe = PW'(x_i);
    ye = PW'(y_i);
    px_d = xe;
    py_d = ye;
    pa_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        px_d = ye;
        py_d = -xe;
        pa_d = qte_pkg::DEG90;
      end else begin
        px_d = -ye;
        py_d = xe;
        pa_d = -qte_pkg::DEG90;
      end
    end
    ax = px_d;
    ay = (py_d < 0) ? PW'(-py_d) : PW'(py_d);
    m = (ax > ay) ? ax : ay;
    pz_d = (m == '0);
    ps_d = '0;
    for (int b = 0; b < PW; b++) begin
      if (m[b]) begin
        ps_d = SW'(qte_pkg::NORM_BIT - b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      pa_q <= pa_d;
      ps_q <= ps_d;
      pz_q <= pz_d;
    end
  end

  // normalizing shift
  logic signed [CW-1:0] x0_q, y0_q;
  logic signed [AW-1:0] a0_q;
  logic                 z0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= CW'(px_q) <<< ps_q;
      y0_q <= CW'(py_q) <<< ps_q;
      a0_q <= pa_q;
      z0_q <= pz_q;
    end
  end

  // micro-rotations
  logic signed [CW-1:0] xi_q [ITER];
  logic signed [CW-1:0] yi_q [ITER];
  logic signed [AW-1:0] ai_q [ITER];
  logic                 zi_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [CW-1:0] xin, yin, xs, ys;
    logic signed [AW-1:0] ain;
    logic                 zin;

    if (i == 0) begin : g_first
      assign xin = x0_q;
      assign yin = y0_q;
      assign ain = a0_q;
      assign zin = z0_q;
    end else begin : g_next
      assign xin = xi_q[i-1];
      assign yin = yi_q[i-1];
      assign ain = ai_q[i-1];
      assign zin = zi_q[i-1];
    end

    assign xs = xin >>> i;
    assign ys = yin >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yin >= 0) begin
          xi_q[i] <= xin + ys;
          yi_q[i] <= yin - xs;
          ai_q[i] <= ain + qte_pkg::ATAN_TAB[i];
        end else begin
          xi_q[i] <= xin - ys;
          yi_q[i] <= yin + xs;
          ai_q[i] <= ain - qte_pkg::ATAN_TAB[i];
        end
        zi_q[i] <= zin;
      end
    end
  end

  assign ang_o = zi_q[ITER-1] ? '0 : ai_q[ITER-1];

endmodule

>>> sv/quaternion_to_euler_angles.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles
// Raw quaternion to aerospace heading, pitch and roll in 1/128 degree.
// ---------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                       tuser
// s_axis   in   quat_w, quat_x, quat_y, quat_z (16 each)  -
// m_axis   out  heading_angle 16, pitch_angle 15,          angles_valid
//               roll_angle 16, 1 pad bit
//
// One item per cycle while the output is not stalled. Pipeline: 5 product and
// sum stages, 32 square-root stages, the CORDIC (iterations + 2), output reg.
// The square root for the pitch cosine sets the depth.
// Reset clears the valid bits only. A stalled output freezes the whole pipe;
// s_axis_tready_o drops only while the output item waits.
// ---------------------------------------------------------------------------
`include "quaternion_to_euler_angles_assert.svh"

module quaternion_to_euler_angles #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // heading_angle, pitch_angle, roll_angle, pad
  output logic        m_axis_tuser_o    // angles_valid
);

  localparam int VW = qte_pkg::VW;
  localparam int AW = qte_pkg::AW;
  localparam int SQ_N = 32;
  localparam int CL = CORDIC_ITERATIONS + 2;
  localparam int VL = 5 + SQ_N + CL;

  logic pipe_en, s_acc;
  logic [VL-1:0] vld_q;
  logic out_vld_q;

  assign pipe_en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;
  assign s_acc = s_axis_tvalid_i && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[VL-2:0], s_acc};
      out_vld_q <= vld_q[VL-1];
    end
  end

  // stage 1: products in the aerospace frame
  logic signed [15:0] qw, xa, ya;
  logic signed [16:0] za;
  logic signed [33:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, wx_q, yz_q, wy_q, xz_q;

  assign qw = s_axis_tdata_i[15:0];
  assign ya = s_axis_tdata_i[31:16];
  assign xa = s_axis_tdata_i[47:32];
  assign za = -17'(signed'(s_axis_tdata_i[63:48]));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ww_q <= 34'(qw * qw);
      xx_q <= 34'(xa * xa);
      yy_q <= 34'(ya * ya);
      zz_q <= 34'(za * za);
      xy_q <= 34'(xa * ya);
      wz_q <= 34'(qw * za);
      wx_q <= 34'(qw * xa);
      yz_q <= 34'(ya * za);
      wy_q <= 34'(qw * ya);
      xz_q <= 34'(xa * za);
    end
  end

  // stage 2: norm and vector terms
  logic signed [VW-1:0] n2_d, n2_q, hx_q, hy_q, rx_q, ry_q, p_q;

  assign n2_d = VW'(ww_q) + VW'(xx_q) + VW'(yy_q) + VW'(zz_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      n2_q <= n2_d;
      hy_q <= (VW'(xy_q) + VW'(wz_q)) <<< 1;
      hx_q <= n2_d - (VW'(yy_q) <<< 1) - (VW'(zz_q) <<< 1);
      ry_q <= (VW'(wx_q) + VW'(yz_q)) <<< 1;
      rx_q <= n2_d - (VW'(xx_q) <<< 1) - (VW'(yy_q) <<< 1);
      p_q  <= (VW'(wy_q) - VW'(xz_q)) <<< 1;
    end
  end

  // stage 3: flags and square-root operands
  qte_pkg::side_t s3_q, s4_q, s5_q;
  logic signed [VW-1:0] pabs;
  logic [33:0] a_q, b_q;
  logic [50:0] pl_q, ph_q;
  logic [63:0] v5_q;

  assign pabs = (p_q < 0) ? -p_q : p_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_q.hx <= hx_q;
      s3_q.hy <= hy_q;
      s3_q.rx <= rx_q;
      s3_q.ry <= ry_q;
      s3_q.p  <= p_q;
      s3_q.nz <= (n2_q == '0);
      s3_q.sp <= (p_q >= n2_q);
      s3_q.sn <= (p_q <= -n2_q);
      a_q <= 34'(n2_q - pabs);
      b_q <= 34'(n2_q + pabs);
      // stage 4: partial products
      s4_q <= s3_q;
      pl_q <= 51'(a_q) * 51'(b_q[16:0]);
      ph_q <= 51'(a_q) * 51'(b_q[33:17]);
      // stage 5: cos^2 term, modulo 2^64
      s5_q <= s4_q;
      v5_q <= 64'(pl_q) + (64'(ph_q) << 17);
    end
  end

  // square root, one result bit per stage
  logic [63:0] sq_r_q [SQ_N];
  logic [63:0] sq_v_q [SQ_N];
  qte_pkg::side_t sq_s_q [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
    logic [63:0] rin, vin, tsum;
    qte_pkg::side_t sin;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign vin = v5_q;
      assign sin = s5_q;
    end else begin : g_next
      assign rin = sq_r_q[k-1];
      assign vin = sq_v_q[k-1];
      assign sin = sq_s_q[k-1];
    end

    assign tsum = rin + BIT;

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        if (vin >= tsum) begin
          sq_v_q[k] <= vin - tsum;
          sq_r_q[k] <= (rin >> 1) + BIT;
        end else begin
          sq_v_q[k] <= vin;
          sq_r_q[k] <= rin >> 1;
        end
        sq_s_q[k] <= sin;
      end
    end
  end

  qte_pkg::side_t sl;
  logic signed [VW-1:0] pc;

  assign sl = sq_s_q[SQ_N-1];
  assign pc = VW'(sq_r_q[SQ_N-1][32:0]);

  // three CORDICs in parallel
  logic signed [AW-1:0] ang_h, ang_r, ang_p;

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_head (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .x_i   (sl.hx),
    .y_i   (sl.hy),
    .ang_o (ang_h)
  );

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_roll (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .x_i   (sl.rx),
    .y_i   (sl.ry),
    .ang_o (ang_r)
  );

  qte_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_pitch (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .x_i   (pc),
    .y_i   (sl.p),
    .ang_o (ang_p)
  );

  qte_pkg::flags_t fl_q [CL];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fl_q[0] <= '{nz: sl.nz, sp: sl.sp, sn: sl.sn};
      for (int j = 1; j < CL; j++) begin
        fl_q[j] <= fl_q[j-1];
      end
    end
  end

  // rounding, wrap and clamp
  qte_pkg::flags_t fo;
  logic signed [17:0] hd0, hd1, hd2, rl0, rl1, pt0, pt1;
  logic [15:0] head_d, roll_d;
  logic [14:0] pitch_d;

  assign fo = fl_q[CL-1];

  always_comb begin
    hd0 = 18'((27'(ang_h) + 27'sd256) >>> 9);
    rl0 = 18'((27'(ang_r) + 27'sd256) >>> 9);
    pt0 = 18'((27'(ang_p) + 27'sd256) >>> 9);
    hd1 = (hd0 < 0) ? hd0 + qte_pkg::HEAD_FULL : hd0;
    hd2 = (hd1 >= qte_pkg::HEAD_FULL) ? hd1 - qte_pkg::HEAD_FULL : hd1;
    rl1 = rl0;
    if (rl0 > qte_pkg::ROLL_LIM) begin
      rl1 = qte_pkg::ROLL_LIM;
    end else if (rl0 < -qte_pkg::ROLL_LIM) begin
      rl1 = -qte_pkg::ROLL_LIM;
    end
    pt1 = pt0;
    if (fo.sp || pt0 > qte_pkg::PITCH_LIM) begin
      pt1 = qte_pkg::PITCH_LIM;
    end else if (fo.sn || pt0 < -qte_pkg::PITCH_LIM) begin
      pt1 = -qte_pkg::PITCH_LIM;
    end
    head_d = hd2[15:0];
    roll_d = rl1[15:0];
    pitch_d = pt1[14:0];
    if (fo.nz) begin
      head_d = '0;
      roll_d = '0;
      pitch_d = '0;
    end
  end

  logic [47:0] tdata_q;
  logic        tuser_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tdata_q <= {1'b0, roll_d, pitch_d, head_d};
      tuser_q <= !fo.nz;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = tdata_q;
  assign m_axis_tuser_o = tuser_q;

  `QTE_ASSERT_NOW(a_zero_quat, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0, "zero quaternion with nonzero angles")
  `QTE_ASSERT_NOW(a_head_rng, m_axis_tvalid_o, m_axis_tdata_o[15:0] < 16'd46080, "heading out of range")
  `QTE_ASSERT_NOW(a_pitch_rng, m_axis_tvalid_o, ($signed(m_axis_tdata_o[30:16]) <= 15'sd11520) && ($signed(m_axis_tdata_o[30:16]) >= -15'sd11520), "pitch out of range")
  `QTE_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(vld_q) && $stable(tdata_q), "pipeline moved during stall")

endmodule

>>> tb/sv/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_quaternion_to_euler_angles
// Streams raw quaternions into the block and checks heading, pitch, roll and
// the valid flag of every output item against an in-bench CORDIC predictor or a typed expectation.
// ---------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;

  localparam int ITERS     = 16;
  localparam int N_RANDOM  = 900;
  localparam int WDOG_MAX  = 4000;
  localparam int HOLD_LONG = 300;

  typedef struct packed {
    logic [15:0] heading;
    logic [14:0] pitch;
    logic [15:0] roll;
    logic        valid;
  } angles_t;

  typedef struct {
    logic [15:0] w, x, y, z;
    bit          has_exp;
    angles_t     exp;
  } quat_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  angles_t expected_angles_q[$];
  int      n_mismatch = 0;
  int      n_checked = 0;
  int      n_invalid = 0;
  int      idle_cycles = 0;
  bit      hold_off = 1'b0;

  quaternion_to_euler_angles #(.CORDIC_ITERATIONS(ITERS)) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint ang, m, xs, ys, t;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = qte_pkg::DEG90;
      end else begin
        x = -y; y = t; ang = -qte_pkg::DEG90;
      end
    end
    m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
    while (m < (64'sd1 <<< qte_pkg::NORM_BIT)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    for (int i = 0; i < ITERS && i < qte_pkg::TAB_LEN; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; ang += qte_pkg::ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; ang -= qte_pkg::ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic longint deg128(longint a);
    return shr_floor(a + 256, 9);
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angles_t predict_angles(logic [15:0] qw, qx, qy, qz);
    longint w, xa, ya, za, n2, hd, pt, rl, p, ap;
    longint unsigned c;
    angles_t r;
    w  = longint'($signed(qw));
    xa = longint'($signed(qy));
    ya = longint'($signed(qx));
    za = -longint'($signed(qz));
    n2 = w*w + xa*xa + ya*ya + za*za;
    r = '0;
    if (n2 == 0) return r;
    hd = deg128(cordic_atan2(2*(xa*ya + w*za), n2 - 2*ya*ya - 2*za*za));
    if (hd < 0) hd += 46080;
    if (hd >= 46080) hd -= 46080;
    rl = clip(deg128(cordic_atan2(2*(w*xa + ya*za), n2 - 2*xa*xa - 2*ya*ya)), 23040);
    p = 2*(w*ya - xa*za);
    if (p >= n2) pt = 11520;
    else if (p <= -n2) pt = -11520;
    else begin
      ap = p < 0 ? -p : p;
      c = int_sqrt(longint'(n2 - ap) * longint'(n2 + ap));
      pt = clip(deg128(cordic_atan2(p, longint'(c))), 11520);
    end
    r.heading = hd[15:0];
    r.pitch   = pt[14:0];
    r.roll    = rl[15:0];
    r.valid   = 1'b1;
    return r;
  endfunction

  task automatic send_quat(logic [15:0] w, x, y, z, bit has_exp, angles_t exp_typed);
    angles_t pred;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x, w};
    pred = predict_angles(w, x, y, z);
    if (has_exp && pred !== exp_typed)
      $display("note: typed row %h %h %h %h differs from predictor", w, x, y, z);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_angles_q.push_back(has_exp ? exp_typed : pred);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_LONG) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      m_axis_tready_i <= (gap == 0);
      @(posedge clk_i);
      if (gap != 0) begin
        repeat (gap - 1) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
      while (!(m_axis_tvalid_o && m_axis_tready_i)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    angles_t got, exp_a;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.heading = m_axis_tdata_o[15:0];
      got.pitch   = m_axis_tdata_o[30:16];
      got.roll    = m_axis_tdata_o[46:31];
      got.valid   = m_axis_tuser_o;
      if (expected_angles_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected output item %h", m_axis_tdata_o);
      end else begin
        exp_a = expected_angles_q.pop_front();
        n_checked++;
        if (!got.valid) n_invalid++;
        if (got !== exp_a) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp hd=%0d pt=%0d rl=%0d v=%b got hd=%0d pt=%0d rl=%0d v=%b",
                     exp_a.heading, $signed(exp_a.pitch), $signed(exp_a.roll), exp_a.valid,
                     got.heading, $signed(got.pitch), $signed(got.roll), got.valid);
        end
      end
    end
  end

  // watchdog on accepted items
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("timeout waiting on handshakes");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    quat_row_t rows[$];
    logic [15:0] v[4];
    int tail;
    // zero quaternion, identity, extremes, gimbal lock, pitch saturation
    rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '0});
    rows.push_back('{16'h4000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'd0, 15'd0, 16'd0, 1'b1}});
    rows.push_back('{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h8000, 16'h0000, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h0000, 16'h4000, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h0000, 16'h0000, 16'h4000, 16'h0000, 0, '0});
    rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h4000, 0, '0});
    rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h8000, 0, '0});
    rows.push_back('{16'h2D41, 16'h2D41, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h2D41, 16'hD2BF, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h2000, 16'h2000, 16'h2000, 16'h2000, 0, '0});
    rows.push_back('{16'h2000, 16'hE000, 16'h2000, 16'hE000, 0, '0});
    rows.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0});
    rows.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0});
    rows.push_back('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, '0});
    rows.push_back('{16'h0001, 16'h0000, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 0, '0});
    rows.push_back('{16'h2D41, 16'h0000, 16'h0000, 16'h2D41, 0, '0});
    rows.push_back('{16'h0000, 16'h0000, 16'h2D41, 16'h2D41, 0, '0});
    rows.push_back('{16'h3000, 16'h0100, 16'h0000, 16'hFF00, 0, '0});

    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                                rows[i].has_exp, rows[i].exp);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_off = 1'b1;
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 9))
          0: v[k] = 16'h0000;
          1: v[k] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          2: v[k] = 16'($urandom_range(0, 15)) - 16'd8;
          default: v[k] = 16'($urandom());
        endcase
      end
      // for one item in three, scale toward 16384 range
      if ($urandom_range(0, 2) == 0)
        for (int k = 0; k < 4; k++) v[k] = {{2{v[k][15]}}, v[k][15:2]};
      if ($urandom_range(0, 40) == 0) v = '{16'h0, 16'h0, 16'h0, 16'h0};
      send_quat(v[0], v[1], v[2], v[3], 0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_angles_q.size() != 0) @(posedge clk_i);
    tail = 0;
    while (tail < 2 * (ITERS + 38)) begin
      @(posedge clk_i);
      tail++;
    end
    $display("covered %0d quaternions (%0d zero), directed extremes, random stalls",
             n_checked, n_invalid);
    $display("and a %0d-cycle output hold-off; %0d mismatches", HOLD_LONG, n_mismatch);
    if (n_mismatch == 0 && expected_angles_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
